[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the reply frame parser.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define SERFP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("serfp assertion failed");

// checked on every edge, reset included
`define SERFP_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("serfp assertion failed");

`endif

[rtl/core/serfp_pkg.sv]
// ---------------------------------------------------------------------------
// serfp_pkg
// Types, codes and byte constants of the reply frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

package serfp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned IDX_W  = 5;

   localparam logic [BYTE_W-1:0] CH_STX  = 8'h02;
   localparam logic [BYTE_W-1:0] CH_ETX  = 8'h03;
   localparam logic [BYTE_W-1:0] CH_PING = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_S    = 8'h73;
   localparam logic [BYTE_W-1:0] CH_D    = 8'h64;
   localparam logic [BYTE_W-1:0] CH_R    = 8'h72;
   localparam logic [BYTE_W-1:0] CH_I    = 8'h69;
   localparam logic [BYTE_W-1:0] CH_P    = 8'h70;
   localparam logic [BYTE_W-1:0] CH_C    = 8'h63;
   localparam logic [BYTE_W-1:0] CH_A    = 8'h61;
   localparam logic [BYTE_W-1:0] CH_Z    = 8'h7A;

   typedef enum logic [3:0] {
      EV_PING = 4'd0,
      EV_S    = 4'd1,
      EV_D    = 4'd2,
      EV_R    = 4'd3,
      EV_I    = 4'd4,
      EV_P    = 4'd5,
      EV_C    = 4'd6,
      EV_A    = 4'd7,
      EV_Z    = 4'd8
   } ev_kind_type;

   typedef struct packed {
      logic        known;
      logic        is_str;
      ev_kind_type kind;
   } kind_info_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KIND,
      ST_THIRD,
      ST_PING,
      ST_ONE,
      ST_STR
   } ctrl_state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_PING,
      EMIT_ONE,
      EMIT_STR
   } emit_sel_type;

   typedef struct packed {
      logic         accept;
      logic         load_kind;
      logic         load_third;
      logic         rd_two;
      emit_sel_type emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic disp;       // accepted byte closes a dispatchable frame
      logic ping;       // accepted byte is a ping
      logic ping_pend;
      logic has_more;   // dispatch yields results
      logic is_str;
      logic load_ok;    // output register can take a result
      logic str_last;
   } dpath_stat_type;

   function automatic kind_info_type kind_decode(input logic [BYTE_W-1:0] b);
      kind_info_type k;
      k.known  = 1'b1;
      k.is_str = 1'b0;
      k.kind   = EV_PING;
      case (b)
         CH_S: k.kind = EV_S;
         CH_D: k.kind = EV_D;
         CH_R: k.kind = EV_R;
         CH_I: k.kind = EV_I;
         CH_P: k.kind = EV_P;
         CH_C: begin
            k.kind   = EV_C;
            k.is_str = 1'b1;
         end
         CH_A: begin
            k.kind   = EV_A;
            k.is_str = 1'b1;
         end
         CH_Z: begin
            k.kind   = EV_Z;
            k.is_str = 1'b1;
         end
         default: k.known = 1'b0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

[rtl/core/serfp_ram.sv]
// ---------------------------------------------------------------------------
// serfp_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module serfp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 30,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/serfp_ctrl.sv]
// ---------------------------------------------------------------------------
// serfp_ctrl
// Sequencer: takes a byte, reads the frame kind and third byte on dispatch,
// then steps the result emission.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module serfp_ctrl
   import serfp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire dpath_stat_type stat,
   output ctrl_cmd_type        cmd
);

   ctrl_state_type state_ff, state_in;
   logic           str_src_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (stat.disp) begin
                  state_in = ST_KIND;
               end else if (stat.ping) begin
                  state_in = ST_PING;
               end
            end
         end
         ST_KIND: state_in = ST_THIRD;
         ST_THIRD: begin
            if (stat.ping_pend) begin
               state_in = ST_PING;
            end else if (stat.has_more) begin
               state_in = stat.is_str ? ST_STR : ST_ONE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PING: begin
            if (stat.load_ok) begin
               if (stat.has_more) begin
                  state_in = stat.is_str ? ST_STR : ST_ONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ONE: begin
            if (stat.load_ok) begin
               state_in = ST_IDLE;
            end
         end
         ST_STR: begin
            if (stat.load_ok && stat.str_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.emit       = EMIT_NONE;
      req_stall      = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_KIND: begin
            cmd.load_kind = 1'b1;
            cmd.rd_two    = 1'b1;
         end
         ST_THIRD: cmd.load_third = 1'b1;
         ST_PING:  cmd.emit = EMIT_PING;
         ST_ONE:   cmd.emit = EMIT_ONE;
         ST_STR:   cmd.emit = EMIT_STR;
         default:  cmd.emit = EMIT_NONE;
      endcase
   end

   assign str_src_ok = (state_ff == ST_THIRD) || (state_ff == ST_PING) || (state_ff == ST_STR);

   // string emission is only reached after the third byte has been read
   `SERFP_ASSERT(a_str_entry, clock, reset, (state_ff == ST_STR) |-> $past(str_src_ok))

endmodule

`default_nettype wire

[rtl/core/serfp_dpath.sv]
// ---------------------------------------------------------------------------
// serfp_dpath
// Frame store, fill count, mode and valid flags, string copy counter and
// the result output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module serfp_dpath
   import serfp_pkg::*;
#(
   parameter int unsigned FRAME_DEPTH    = 30,
   parameter int unsigned SHORT_COPY_LEN = 10,
   parameter int unsigned LONG_COPY_LEN  = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctrl_cmd_type      cmd,
   output dpath_stat_type         stat,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [3:0]             rsp_event_kind,
   output logic [IDX_W-1:0]       rsp_char_index,
   output logic [BYTE_W-1:0]      rsp_char_value,
   output logic                   rsp_serial_mode,
   output logic                   rsp_reply_valid,
   output logic                   rsp_last
);

   localparam int unsigned AW     = $clog2(FRAME_DEPTH);
   localparam int unsigned FILL_W = $clog2(FRAME_DEPTH + 1);
   localparam int unsigned CMP_W  = (FILL_W > IDX_W) ? FILL_W : IDX_W;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] len_ff, len_in;
   logic              mode_ff, mode_in;
   logic              valid_ff, valid_in;
   logic              ping_pend_ff, ping_pend_in;
   logic              disp_pend_ff, disp_pend_in;
   kind_info_type     kind_ff, kind_in;
   logic [BYTE_W-1:0] third_ff, third_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              ended_ff, ended_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [BYTE_W-1:0] rsp_val_ff, rsp_val_in;
   logic              rsp_mode_ff, rsp_mode_in;
   logic              rsp_rv_ff, rsp_rv_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              is_etx_end;
   logic              store_full;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              load_ok;
   logic              str_go;
   logic [IDX_W-1:0]  idx_next;
   logic [IDX_W-1:0]  str_len;
   logic              str_last;
   logic              in_frame;
   logic [BYTE_W-1:0] str_val;
   kind_info_type     kind_dec;

   serfp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign store_full = (fill_ff >= FILL_W'(FRAME_DEPTH));
   assign is_etx_end = (req_rx_byte == CH_ETX) || store_full;
   assign wr_en      = cmd.accept && !is_etx_end && (req_rx_byte != CH_STX);
   assign wr_addr    = AW'(fill_ff);

   assign load_ok  = !rsp_valid_ff || !rsp_stall;
   assign str_go   = (cmd.emit == EMIT_STR) && load_ok;
   assign idx_next = idx_ff + IDX_W'(1);
   assign str_len  = (kind_ff.kind == EV_Z) ? IDX_W'(LONG_COPY_LEN) : IDX_W'(SHORT_COPY_LEN);
   assign str_last = (idx_ff == str_len - IDX_W'(1));

   // read data always belongs to the address issued in the previous cycle
   always_comb begin
      rd_addr = '0;
      if (cmd.rd_two) begin
         rd_addr = AW'(2);
      end else if (cmd.emit == EMIT_STR) begin
         if (!str_go) begin
            rd_addr = AW'(idx_ff);
         end else if (CMP_W'(idx_next) < CMP_W'(FRAME_DEPTH)) begin
            rd_addr = AW'(idx_next);
         end
      end
   end

   assign in_frame = (CMP_W'(idx_ff) < CMP_W'(len_ff)) && (rd_data != '0);
   assign str_val  = (!ended_ff && in_frame) ? rd_data : '0;
   assign kind_dec = kind_decode(rd_data);

   always_comb begin
      fill_in      = fill_ff;
      len_in       = len_ff;
      ping_pend_in = ping_pend_ff;
      disp_pend_in = disp_pend_ff;
      mode_in      = mode_ff;
      valid_in     = valid_ff;
      kind_in      = kind_ff;
      third_in     = third_ff;
      idx_in       = idx_ff;
      ended_in     = ended_ff;
      if (cmd.accept) begin
         ping_pend_in = (req_rx_byte == CH_PING);
         disp_pend_in = is_etx_end && (fill_ff >= FILL_W'(3));
         len_in       = fill_ff;
         if (is_etx_end || (req_rx_byte == CH_STX)) begin
            fill_in = '0;
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
      if (cmd.load_kind) begin
         kind_in = kind_dec;
      end
      if (cmd.load_third) begin
         third_in = rd_data;
         idx_in   = '0;
         ended_in = 1'b0;
         if (disp_pend_ff && kind_ff.known) begin
            if (kind_ff.kind == EV_D) begin
               mode_in = (rd_data == CH_S);
            end else begin
               valid_in = 1'b1;
            end
         end
      end
      if (str_go) begin
         idx_in   = idx_next;
         ended_in = ended_ff || !in_frame;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_ok && (cmd.emit != EMIT_NONE)) begin
         rsp_valid_in = 1'b1;
         rsp_mode_in  = mode_ff;
         rsp_rv_in    = valid_ff;
         case (cmd.emit)
            EMIT_PING: begin
               rsp_kind_in = EV_PING;
               rsp_idx_in  = '0;
               rsp_val_in  = '0;
               rsp_last_in = !(disp_pend_ff && kind_ff.known);
            end
            EMIT_ONE: begin
               rsp_kind_in = kind_ff.kind;
               rsp_idx_in  = '0;
               rsp_val_in  = third_ff;
               rsp_last_in = 1'b1;
            end
            EMIT_STR: begin
               rsp_kind_in = kind_ff.kind;
               rsp_idx_in  = idx_ff;
               rsp_val_in  = str_val;
               rsp_last_in = str_last;
            end
            default: rsp_valid_in = rsp_valid_ff && rsp_stall;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         mode_ff      <= 1'b0;
         valid_ff     <= 1'b0;
         ping_pend_ff <= 1'b0;
         disp_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         mode_ff      <= mode_in;
         valid_ff     <= valid_in;
         ping_pend_ff <= ping_pend_in;
         disp_pend_ff <= disp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      kind_ff     <= kind_in;
      third_ff    <= third_in;
      idx_ff      <= idx_in;
      ended_ff    <= ended_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_mode_ff <= rsp_mode_in;
      rsp_rv_ff   <= rsp_rv_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      stat           = '0;
      stat.disp      = is_etx_end && (fill_ff >= FILL_W'(3));
      stat.ping      = (req_rx_byte == CH_PING);
      stat.ping_pend = ping_pend_ff;
      stat.has_more  = disp_pend_ff && kind_ff.known;
      stat.is_str    = kind_ff.is_str;
      stat.load_ok   = load_ok;
      stat.str_last  = str_last;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_char_index  = rsp_idx_ff;
   assign rsp_char_value  = rsp_val_ff;
   assign rsp_serial_mode = rsp_mode_ff;
   assign rsp_reply_valid = rsp_rv_ff;
   assign rsp_last        = rsp_last_ff;

   // the sticky flag only ever rises
   `SERFP_ASSERT(a_valid_sticky, clock, reset, !$fell(valid_ff))
   // a string emission never runs past its copy length
   `SERFP_ASSERT(a_str_bound, clock, reset, (cmd.emit == EMIT_STR) |-> (idx_ff < str_len))
   `SERFP_ASSERT(a_fill_bound, clock, reset, fill_ff <= FILL_W'(FRAME_DEPTH))

endmodule

`default_nettype wire

[rtl/core/stx_etx_reply_frame_parser_top.sv]
// A stored or dropped byte is taken in IDLE; a ping alone sends the sequencer to PING, which loads the output register.
// A dispatched frame reads kind and third byte from the store in KIND and THIRD, then
// gives one result per cycle while the output does not stall (up to 21 with a ping).
// Throughput: one byte per cycle while bytes only fill the store; bytes are taken one at a time.
// Rate is set by the single read port of the frame store, one string byte per cycle unless the output stalls.
// Reset (synchronous): fill count, mode and valid flags cleared; store content stays undefined.
`default_nettype none

// ---------------------------------------------------------------------------
// stx_etx_reply_frame_parser_top
// Reply frame parser: buffers serial bytes between STX and ETX and emits
// decoded reply events and copied string bytes.
// ---------------------------------------------------------------------------
module stx_etx_reply_frame_parser_top
   import serfp_pkg::*;
#(
   parameter int unsigned FRAME_DEPTH    = 30,
   parameter int unsigned SHORT_COPY_LEN = 10,
   parameter int unsigned LONG_COPY_LEN  = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [3:0]             rsp_event_kind,
   output logic [IDX_W-1:0]       rsp_char_index,
   output logic [BYTE_W-1:0]      rsp_char_value,
   output logic                   rsp_serial_mode,
   output logic                   rsp_reply_valid,
   output logic                   rsp_last
);

   ctrl_cmd_type   cmd;
   dpath_stat_type stat;

   serfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   serfp_dpath #(
      .FRAME_DEPTH    (FRAME_DEPTH),
      .SHORT_COPY_LEN (SHORT_COPY_LEN),
      .LONG_COPY_LEN  (LONG_COPY_LEN)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_char_index  (rsp_char_index),
      .rsp_char_value  (rsp_char_value),
      .rsp_serial_mode (rsp_serial_mode),
      .rsp_reply_valid (rsp_reply_valid),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

[verif/stx_etx_reply_frame_parser_top_test.sv]
// ---------------------------------------------------------------------------
// stx_etx_reply_frame_parser_top_test
// Self-checking bench for the reply frame parser. Serial bytes go in as
// framed replies of every kind, plus broken frames, overflowing frames and
// noise. A scoreboard predicts each request's events and checks them in order.
// ---------------------------------------------------------------------------
module stx_etx_reply_frame_parser_top_test;
   import serfp_pkg::*;

   localparam int unsigned FRAME_DEPTH    = 30;
   localparam int unsigned SHORT_COPY_LEN = 10;
   localparam int unsigned LONG_COPY_LEN  = 20;
   localparam int unsigned RANDOM_ITEMS   = 190;
   localparam int unsigned CYCLE_LIMIT    = 600000;

   typedef struct {
      logic [3:0]       kind;
      logic [IDX_W-1:0] index;
      logic [7:0]       value;
      logic             mode;
      logic             valid;
      logic             last;
   } reply_event_type;

   class reply_event_ledger;
      logic [7:0]      frame_bytes[FRAME_DEPTH];
      int unsigned     fill;
      bit              mode_on;
      bit              reply_seen;
      reply_event_type owed_events[$];
      int unsigned     items;
      int unsigned     checked;
      int unsigned     faults;
      int unsigned     pings;
      int unsigned     dispatches;
      int unsigned     overflows;

      function reply_event_type make_event(ev_kind_type k, int unsigned idx, logic [7:0] v);
         reply_event_type ev;
         ev.kind  = k;
         ev.index = IDX_W'(idx);
         ev.value = v;
         ev.mode  = 1'b0;
         ev.valid = 1'b0;
         ev.last  = 1'b0;
         return ev;
      endfunction

      // works out every event one accepted byte causes
      function void absorb_rx_byte(logic [7:0] b);
         reply_event_type burst[$];
         ev_kind_type     kind;
         logic [7:0]      third;
         logic [7:0]      ch;
         int unsigned     copy_len;
         bit              known;
         bit              ended;
         items++;
         if (b == CH_PING) begin
            burst = {burst, make_event(EV_PING, 0, 8'h00)};
            pings++;
         end
         if (b == CH_ETX || fill >= FRAME_DEPTH) begin
            if (fill >= FRAME_DEPTH) overflows++;
            if (fill >= 3) begin
               third    = frame_bytes[2];
               copy_len = 0;
               known    = 1'b1;
               kind     = EV_PING;
               case (frame_bytes[0])
                  CH_S: kind = EV_S;
                  CH_R: kind = EV_R;
                  CH_I: kind = EV_I;
                  CH_P: kind = EV_P;
                  CH_D: begin
                     kind    = EV_D;
                     mode_on = (third == CH_S);
                  end
                  CH_C: begin
                     kind     = EV_C;
                     copy_len = SHORT_COPY_LEN;
                  end
                  CH_A: begin
                     kind     = EV_A;
                     copy_len = SHORT_COPY_LEN;
                  end
                  CH_Z: begin
                     kind     = EV_Z;
                     copy_len = LONG_COPY_LEN;
                  end
                  default: known = 1'b0;
               endcase
               if (known) begin
                  dispatches++;
                  if (kind != EV_D) reply_seen = 1'b1;
                  if (copy_len == 0) begin
                     burst = {burst, make_event(kind, 0, third)};
                  end else begin
                     // copy stops at a zero byte or the frame end, then pads
                     ended = 1'b0;
                     for (int unsigned i = 0; i < copy_len; i++) begin
                        ch = 8'h00;
                        if (!ended) begin
                           if (i < fill && frame_bytes[i] != 8'h00) ch = frame_bytes[i];
                           else ended = 1'b1;
                        end
                        burst = {burst, make_event(kind, i, ch)};
                     end
                  end
               end
            end
            fill = 0;
         end else if (b == CH_STX) begin
            fill = 0;
         end else begin
            frame_bytes[fill] = b;
            fill++;
         end
         foreach (burst[j]) begin
            burst[j].mode  = mode_on;
            burst[j].valid = reply_seen;
            burst[j].last  = (j == burst.size() - 1);
            owed_events = {owed_events, burst[j]};
         end
      endfunction

      function void compare_field(string what, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            faults++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
         end
      endfunction

      function void check_result(reply_event_type got);
         reply_event_type want;
         if (owed_events.size() == 0) begin
            faults++;
            $display("%0t: unexpected result, expected none actual kind %0h index %0h value %0h",
                     $time, got.kind, got.index, got.value);
            return;
         end
         want = owed_events.pop_front();
         checked++;
         compare_field("event_kind", 8'(want.kind), 8'(got.kind));
         compare_field("char_index", 8'(want.index), 8'(got.index));
         compare_field("char_value", want.value, got.value);
         compare_field("serial_mode", 8'(want.mode), 8'(got.mode));
         compare_field("reply_valid", 8'(want.valid), 8'(got.valid));
         compare_field("last", 8'(want.last), 8'(got.last));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_rx_byte;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [3:0]        rsp_event_kind;
   logic [IDX_W-1:0]  rsp_char_index;
   logic [BYTE_W-1:0] rsp_char_value;
   logic              rsp_serial_mode;
   logic              rsp_reply_valid;
   logic              rsp_last;

   reply_event_ledger ledger = new();
   reply_event_type   seen;
   bit                calm;
   int unsigned       gap_odds;
   int unsigned       stall_odds;
   int unsigned       cycles;
   logic [7:0]        opening_bytes[$];

   stx_etx_reply_frame_parser_top #(
      .FRAME_DEPTH   (FRAME_DEPTH),
      .SHORT_COPY_LEN(SHORT_COPY_LEN),
      .LONG_COPY_LEN (LONG_COPY_LEN)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_char_index (rsp_char_index),
      .rsp_char_value (rsp_char_value),
      .rsp_serial_mode(rsp_serial_mode),
      .rsp_reply_valid(rsp_reply_valid),
      .rsp_last       (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // valid stays high from one request to the next unless a gap is drawn
   task automatic drive_byte(input logic [7:0] b);
      int unsigned pause;
      @(negedge clock);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         pause = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      ledger.absorb_rx_byte(b);
   endtask

   function automatic logic [7:0] frame_content(logic [7:0] lead, int unsigned pos);
      int unsigned r;
      logic [7:0]  b;
      r = $urandom_range(0, 31);
      // pos 1 is the third frame byte
      if (lead == CH_D && pos == 1 && r < 16) return CH_S;
      if (r == 0) return CH_PING;
      if (r == 1) return 8'h00;
      if (r == 2) return 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      if (b == CH_STX || b == CH_ETX) b = b ^ 8'h40;
      return b;
   endfunction

   task automatic random_frame(input bit force_full);
      logic [7:0]  seq[$];
      logic [7:0]  lead;
      int unsigned shape;
      int unsigned body_len;
      int unsigned r;
      shape = force_full ? 0 : $urandom_range(0, 99);
      if (force_full || $urandom_range(0, 3) != 0) seq = {seq, CH_STX};
      case ($urandom_range(0, 9))
         0: lead = CH_S;
         1: lead = CH_D;
         2: lead = CH_R;
         3: lead = CH_I;
         4: lead = CH_P;
         5: lead = CH_C;
         6: lead = CH_A;
         7: lead = CH_Z;
         default: lead = 8'($urandom_range(0, 255));
      endcase
      seq = {seq, lead};
      if (shape < 8) body_len = FRAME_DEPTH - 1;
      else if (shape < 16) body_len = $urandom_range(18, FRAME_DEPTH - 2);
      else if (shape < 26) body_len = $urandom_range(0, 1);
      else body_len = $urandom_range(2, 12);
      for (int unsigned i = 0; i < body_len; i++) seq = {seq, frame_content(lead, i)};
      if (shape < 8) begin
         // store is full unless a random body byte was STX or ETX: whatever comes next closes the frame
         r = force_full ? 0 : $urandom_range(0, 3);
         case (r)
            0: seq = {seq, CH_PING};
            1: seq = {seq, CH_STX};
            2: seq = {seq, CH_ETX};
            default: seq = {seq, 8'($urandom_range(0, 255))};
         endcase
      end else begin
         r = $urandom_range(0, 19);
         if (r < 16) seq = {seq, CH_ETX};
         else if (r < 18) seq = {seq, CH_STX};
      end
      foreach (seq[k]) drive_byte(seq[k]);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind  = rsp_event_kind;
         seen.index = rsp_char_index;
         seen.value = rsp_char_value;
         seen.mode  = rsp_serial_mode;
         seen.valid = rsp_reply_valid;
         seen.last  = rsp_last;
         ledger.check_result(seen);
      end
   end

   initial begin
      int unsigned stall_run;
      int unsigned tick;
      stall_run = 0;
      tick      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (tick % 64 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_odds = 0;
               1: stall_odds = 2;
               default: stall_odds = 6;
            endcase
         end
         tick++;
         if (calm) stall_run = 0;
         else if (stall_run == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            stall_run = $urandom_range(1, 8);
         rsp_stall <= (stall_run != 0);
         if (stall_run != 0) stall_run--;
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: no progress after %0d cycles", $time, cycles);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int unsigned random_target;
      bit          first;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      calm        = 1'b0;
      gap_odds    = 3;
      // kinds s, d, c, z; ping inside a frame; string cut by a zero byte;
      // unknown kind; short frame; byte extremes 00 and FF
      opening_bytes = '{CH_STX, CH_S, 8'h00, 8'hFF, CH_ETX,
                        CH_D, 8'h7F, CH_S, CH_ETX,
                        CH_C, CH_PING, 8'h80, CH_ETX,
                        CH_Z, 8'h01, 8'h00, 8'h55, CH_ETX,
                        8'h71, 8'h01, 8'h02, CH_ETX,
                        CH_R, 8'h77, CH_ETX};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[k]) drive_byte(opening_bytes[k]);

      random_target = ledger.items + RANDOM_ITEMS;
      first = 1'b1;
      while (ledger.items < random_target) begin
         if (ledger.items + 40 > random_target) calm = 1'b1;
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 3;
            default: gap_odds = 8;
         endcase
         if (!first && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) drive_byte(8'($urandom_range(0, 255)));
         end else begin
            random_frame(first);
            first = 1'b0;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.owed_events.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d request bytes: %0d pings, %0d frames dispatched, %0d full-store ends.",
               ledger.items, ledger.pings, ledger.dispatches, ledger.overflows);
      $display("Checked %0d events, %0d field faults.", ledger.checked, ledger.faults);
      if (ledger.faults == 0 && ledger.owed_events.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/serfp_pkg.sv
rtl/core/serfp_ram.sv
rtl/core/serfp_ctrl.sv
rtl/core/serfp_dpath.sv
rtl/core/stx_etx_reply_frame_parser_top.sv
verif/stx_etx_reply_frame_parser_top_test.sv
